// ----- hdl/q2e_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

   localparam int DEF_DATA_WIDTH    = 16;
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int ANGLE_WIDTH       = 16;
   localparam int ACC_WIDTH         = 32;
   localparam int TABLE_LEN         = 30;

   typedef struct packed {
      logic signed [DEF_DATA_WIDTH-1:0] quat_x;
      logic signed [DEF_DATA_WIDTH-1:0] quat_y;
      logic signed [DEF_DATA_WIDTH-1:0] quat_z;
      logic signed [DEF_DATA_WIDTH-1:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic               pitch_clamped;
   } rsp_type;

   function automatic logic [ACC_WIDTH-1:0] atan_entry(input int idx);
      logic [ACC_WIDTH-1:0] v;
      begin
         case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

// ----- hdl/q2e_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined vectoring CORDIC: one stage per iteration, plus a quadrant pre-rotation stage.
module q2e_cordic import q2e_pkg::*; #(
   parameter int W      = 48,
   parameter int STAGES = DEF_CORDIC_STAGES
) (
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire logic signed [W-1:0]  x_in,
   input  wire logic signed [W-1:0]  y_in,
   output logic         [ACC_WIDTH-1:0] angle_out
);
   localparam int NIT = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;

   logic signed [W-1:0]   x_ff [NIT+1];
   logic signed [W-1:0]   y_ff [NIT+1];
   logic [ACC_WIDTH-1:0]  a_ff [NIT+1];
   logic                  z_ff [NIT+1];

   // pre-rotation into the right half plane
   always_ff @(posedge clock) begin
      if (advance) begin
         z_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            if (y_in >= 0) begin
               a_ff[0] <= 32'h40000000;
               x_ff[0] <= y_in;
               y_ff[0] <= -x_in;
            end else begin
               a_ff[0] <= 32'hC0000000;
               x_ff[0] <= -y_in;
               y_ff[0] <= x_in;
            end
         end else begin
            a_ff[0] <= '0;
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
         end
      end
   end

   for (genvar i = 0; i < NIT; i++) begin : g_it
      always_ff @(posedge clock) begin
         if (advance) begin
            z_ff[i+1] <= z_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] + atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] - atan_entry(i);
            end
         end
      end
   end

   assign angle_out = z_ff[NIT] ? '0 : a_ff[NIT];
endmodule
`default_nettype wire

// ----- hdl/q2e_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root of (2^60 - s^2), one result bit per stage.
module q2e_isqrt (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic [60:0]        rad_in,
   output logic      [30:0]        root_out
);
   localparam int NB = 31;

   logic [61:0] rem_ff  [NB+1];
   logic [30:0] root_ff [NB+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= {1'b0, rad_in};
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < NB; k++) begin : g_bit
      localparam int B = NB - 1 - k;
      logic [61:0] trial;
      assign trial = ({31'd0, root_ff[k]} << (B + 1)) + (62'd1 << (2 * B));
      always_ff @(posedge clock) begin
         if (advance) begin
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1]  <= rem_ff[k] - trial;
               root_ff[k+1] <= root_ff[k] | (31'd1 << B);
            end else begin
               rem_ff[k+1]  <= rem_ff[k];
               root_ff[k+1] <= root_ff[k];
            end
         end
      end
   end

   assign root_out = root_ff[NB];
endmodule
`default_nettype wire

// ----- hdl/quaternion_to_euler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Quaternion to Z-Y-X Euler angles.
// Request channel: req_valid/req_stall with req_data carrying x, y, z, w in
// signed Q2.14. Response channel: rsp_valid/rsp_stall with rsp_data carrying
// roll, pitch and yaw as 16-bit binary angles (32768 = pi) and a flag that
// reports a saturated asin argument.
// Throughput: one beat per cycle unless the output stalls. Stages: capture,
// products and sums take three stages; pitch then passes the s30 register, the
// root load and a 31-stage square root, and roll, yaw and the flag are delayed
// to match; then the CORDIC pre-rotation, the CORDIC iterations (CORDIC_STAGES,
// at most the table length) and the output register.
// The pipeline is one shift of valid bits: on a stall with the last stage full
// the whole pipeline holds, and req_stall follows, so no beat is lost or
// repeated. Bubbles inside the pipeline are held too, not squeezed out.
// Reset clears all valid bits; data registers are left alone.
module quaternion_to_euler import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int DATA_WIDTH = DEF_DATA_WIDTH;
   localparam int FRAC  = DATA_WIDTH - 2;
   localparam int PSH   = (2 * FRAC > 40) ? (2 * FRAC - 40) : 0;
   localparam int WF    = 2 * FRAC - PSH;
   localparam int PW    = 2 * DATA_WIDTH - PSH;   // product width
   localparam int SW    = PW + 3;                 // doubled sum width
   localparam int NIT   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int SQ_LAT = 1 + 1 + 31;            // s30 reg, root load, root stages
   localparam int DEPTH = 3 + SQ_LAT + 1 + NIT + 1; // total valid stages
   localparam int DLY   = SQ_LAT;                 // roll/yaw delay before CORDIC

   // Hold everything while the output is occupied and stalled.
   logic [DEPTH-1:0] vld_ff;
   logic             advance;
   assign advance   = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // Stage 1: capture the inputs.
   logic signed [DATA_WIDTH-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         qx_ff <= DATA_WIDTH'(req_data.quat_x);
         qy_ff <= DATA_WIDTH'(req_data.quat_y);
         qz_ff <= DATA_WIDTH'(req_data.quat_z);
         qw_ff <= DATA_WIDTH'(req_data.quat_w);
      end
   end

   // Stage 2: products, floor-shifted.
   logic signed [PW-1:0] wx_ff, zy_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;
   function automatic logic signed [PW-1:0] mulw(input logic signed [DATA_WIDTH-1:0] a,
                                                 input logic signed [DATA_WIDTH-1:0] b);
      logic signed [2*DATA_WIDTH-1:0] p;
      begin
         p = a * b;
         return PW'(p >>> PSH);
      end
   endfunction
   always_ff @(posedge clock) begin
      if (advance) begin
         wx_ff <= mulw(qw_ff, qx_ff);
         zy_ff <= mulw(qz_ff, qy_ff);
         xx_ff <= mulw(qx_ff, qx_ff);
         yy_ff <= mulw(qy_ff, qy_ff);
         wz_ff <= mulw(qw_ff, qz_ff);
         xy_ff <= mulw(qx_ff, qy_ff);
         zz_ff <= mulw(qz_ff, qz_ff);
         wy_ff <= mulw(qw_ff, qy_ff);
         xz_ff <= mulw(qx_ff, qz_ff);
      end
   end

   // Stage 3: sums, clamp of the asin argument.
   localparam logic signed [SW-1:0] ONE = SW'(1) <<< WF;
   logic signed [SW-1:0] rnum_ff, rden_ff, ynum_ff, yden_ff, s_ff;
   logic                 clamp_ff;
   logic signed [SW-1:0] s_raw;
   assign s_raw = (SW'(wy_ff) - SW'(xz_ff)) <<< 1;
   always_ff @(posedge clock) begin
      if (advance) begin
         rnum_ff <= (SW'(wx_ff) + SW'(zy_ff)) <<< 1;
         rden_ff <= ONE - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
         ynum_ff <= (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
         yden_ff <= ONE - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
         if (s_raw > ONE) begin
            s_ff <= ONE;  clamp_ff <= 1'b1;
         end else if (s_raw < -ONE) begin
            s_ff <= -ONE; clamp_ff <= 1'b1;
         end else begin
            s_ff <= s_raw; clamp_ff <= 1'b0;
         end
      end
   end

   // Pitch path: bring s to Q30, square, root.
   logic signed [31:0] s30_ff;
   logic [60:0]        rad;
   logic signed [63:0] s30_sq;
   always_ff @(posedge clock) begin
      if (advance) begin
         if (WF >= 30) s30_ff <= 32'(s_ff >>> (WF - 30));
         else          s30_ff <= 32'((SW + 32)'(s_ff) <<< (30 - WF));
      end
   end
   // s30 within +-2^30; the square fits the 32x32 multiplier
   assign s30_sq = s30_ff * s30_ff;
   assign rad    = 61'((64'd1 << 60) - 64'(s30_sq));

   logic [30:0] root;
   q2e_isqrt u_sqrt (.clock(clock), .advance(advance), .rad_in(rad), .root_out(root));

   // Delay s30 alongside the root.
   logic signed [31:0] s30_d_ff [32];
   always_ff @(posedge clock) begin
      if (advance) begin
         s30_d_ff[0] <= s30_ff;
         for (int k = 1; k < 32; k++) s30_d_ff[k] <= s30_d_ff[k-1];
      end
   end

   // Roll/yaw operands and clamp flag wait for the root to finish.
   logic signed [SW-1:0] rn_d [DLY], rd_d [DLY], yn_d [DLY], yd_d [DLY];
   logic                 cl_d [DLY+NIT+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         rn_d[0] <= rnum_ff; rd_d[0] <= rden_ff;
         yn_d[0] <= ynum_ff; yd_d[0] <= yden_ff;
         cl_d[0] <= clamp_ff;
         for (int k = 1; k < DLY; k++) begin
            rn_d[k] <= rn_d[k-1]; rd_d[k] <= rd_d[k-1];
            yn_d[k] <= yn_d[k-1]; yd_d[k] <= yd_d[k-1];
         end
         for (int k = 1; k < DLY + NIT + 1; k++) cl_d[k] <= cl_d[k-1];
      end
   end
   logic [ACC_WIDTH-1:0] roll_acc, yaw_acc, pitch_acc;
   q2e_cordic #(.W(SW), .STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .advance(advance),
      .x_in(rd_d[DLY-1]), .y_in(rn_d[DLY-1]), .angle_out(roll_acc));
   q2e_cordic #(.W(SW), .STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .advance(advance),
      .x_in(yd_d[DLY-1]), .y_in(yn_d[DLY-1]), .angle_out(yaw_acc));
   q2e_cordic #(.W(33), .STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .advance(advance),
      .x_in({2'b00, root}), .y_in(33'(s30_d_ff[31])), .angle_out(pitch_acc));

   function automatic logic signed [ANGLE_WIDTH-1:0] to_a16(input logic [ACC_WIDTH-1:0] a);
      logic [ACC_WIDTH-1:0] t;
      begin
         t = a + 32'h8000;
         return t[31:16];
      end
   endfunction

   // Output register.
   logic signed [ANGLE_WIDTH-1:0] p16;
   assign p16 = to_a16(pitch_acc);
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data.roll_angle    <= to_a16(roll_acc);
         rsp_data.yaw_angle     <= to_a16(yaw_acc);
         rsp_data.pitch_clamped <= cl_d[DLY+NIT];
         if (p16 > 16'sd16384)       rsp_data.pitch_angle <= 16'sd16384;
         else if (p16 < -16'sd16384) rsp_data.pitch_angle <= -16'sd16384;
         else                        rsp_data.pitch_angle <= p16;
      end
   end
endmodule
`default_nettype wire
